@@ design/esc_pkg.sv @@
// Shared types and constants for the elevator scan scheduler.
// Used by esc_cell, esc_ctrl and elevator_scan_scheduler_top; no dependencies.
package esc_pkg;

  localparam int unsigned SlotW = 6;
  localparam int unsigned FloorW = 6;
  localparam int unsigned MapBits = 33;
  localparam int unsigned BaseSlots = 3;
  localparam int unsigned DefStopSlots = 33;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [4:0] TopFloorReset = 5'd30;

  localparam logic RegBasement = 1'b0;
  localparam logic RegTopFloor = 1'b1;

  typedef enum logic [2:0] {
    MotStop     = 3'd0,
    MotUp       = 3'd1,
    MotDown     = 3'd2,
    MotWaitUp   = 3'd3,
    MotWaitDown = 3'd4
  } motion_e;

  typedef struct packed {
    logic [SlotW-1:0] car;
    logic [SlotW:0]   car_p1;
    logic             set_en;
    logic [SlotW-1:0] set_slot;
    logic             clr_en;
  } cell_cmd_t;

  typedef struct packed {
    logic at_car;
    logic below_car;
    logic above_car;
    logic at_up;
    logic above_up;
    logic at_dn;
    logic below_dn;
  } cell_view_t;

  function automatic logic [FloorW-1:0] floor_of(input logic [SlotW-1:0] slot,
                                                 input logic [1:0] base);
    logic [FloorW-1:0] f;
    if (base == 2'd0) begin
      f = slot + FloorW'(1);
    end else if (slot >= SlotW'(BaseSlots)) begin
      f = slot - FloorW'(2);
    end else begin
      f = slot - FloorW'(3);
    end
    return f;
  endfunction

endpackage

@@ design/esc_cell.sv @@
// One stop slot of the request chain: holds the request bit, passes the
// below and above request flags to its neighbors. Depends on esc_pkg.
module esc_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  esc_pkg::cell_cmd_t  cmd_i,
  input  logic                lo_i,
  input  logic                hi_i,
  output logic                lo_o,
  output logic                hi_o,
  output logic                bit_d_o,
  output esc_pkg::cell_view_t view_o
);
  import esc_pkg::*;

  logic bit_q, bit_d;
  logic sel, sel_up, sel_dn, set_hit, clr_hit;

  assign sel     = cmd_i.car == SlotW'(Idx);
  assign sel_up  = cmd_i.car_p1 == (SlotW + 1)'(Idx);
  assign sel_dn  = {1'b0, cmd_i.car} == (SlotW + 1)'(Idx + 1);
  assign set_hit = cmd_i.set_en && (cmd_i.set_slot == SlotW'(Idx));
  assign clr_hit = cmd_i.clr_en && sel;

  assign bit_d   = (bit_q | set_hit) & ~clr_hit;
  assign bit_d_o = bit_d;

  assign lo_o = lo_i | bit_q;
  assign hi_o = hi_i | bit_q;

  assign view_o.at_car    = sel & bit_q;
  assign view_o.below_car = sel & lo_i;
  assign view_o.above_car = sel & hi_i;
  assign view_o.at_up     = sel_up & bit_q;
  assign view_o.above_up  = sel_up & hi_i;
  assign view_o.at_dn     = sel_dn & bit_q;
  assign view_o.below_dn  = sel_dn & lo_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

endmodule

@@ design/esc_ctrl.sv @@
// Car position and motion state machine of the scan scheduler.
// Decides service, direction and arrival from the cell chain view. Depends on esc_pkg.
module esc_ctrl #(
  parameter int unsigned StopSlots = esc_pkg::DefStopSlots
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tick_i,
  input  esc_pkg::cell_view_t        view_i,
  input  logic                       all_or_i,
  input  logic                       car_load_i,
  input  logic [esc_pkg::SlotW-1:0]  car_load_slot_i,
  output logic [esc_pkg::SlotW-1:0]  car_o,
  output logic [esc_pkg::SlotW:0]    car_p1_o,
  output logic [esc_pkg::SlotW-1:0]  car_d_o,
  output esc_pkg::motion_e           motion_d_o,
  output logic                       served_o
);
  import esc_pkg::*;

  logic [SlotW-1:0] car_q, car_d;
  logic [SlotW:0]   car_p1;
  motion_e          motion_q, motion_d, motion_mid;
  logic             served, keep, top_hit, beyond, beyond_dn;
  logic             below_car, above_car, below_dn;

  assign car_p1    = {1'b0, car_q} + (SlotW + 1)'(1);
  assign top_hit   = car_p1 >= (SlotW + 1)'(StopSlots);
  assign beyond    = {1'b0, car_q} >= (SlotW + 1)'(StopSlots);
  assign beyond_dn = {1'b0, car_q} > (SlotW + 1)'(StopSlots);

  assign below_car = view_i.below_car | (beyond & all_or_i);
  assign above_car = view_i.above_car;
  assign below_dn  = view_i.below_dn | (beyond_dn & all_or_i);

  always_comb begin
    served     = 1'b0;
    motion_mid = motion_q;
    motion_d   = motion_q;
    car_d      = car_q;
    keep       = 1'b0;
    if (tick_i) begin
      unique case (motion_q) inside
        MotStop, MotWaitUp, MotWaitDown: begin
          if (view_i.at_car) begin
            served = 1'b1;
            if (motion_q == MotWaitUp) begin
              motion_mid = MotUp;
            end else if (motion_q == MotWaitDown) begin
              motion_mid = MotDown;
            end
          end else if (below_car) begin
            motion_mid = MotDown;
          end else if (above_car) begin
            motion_mid = MotUp;
          end
        end
        default: ;
      endcase
      keep = view_i.at_car & ~served;
      if (motion_mid == MotUp) begin
        if (top_hit) begin
          motion_d = MotStop;
        end else begin
          car_d = car_p1[SlotW-1:0];
          if (!view_i.at_up) begin
            motion_d = MotUp;
          end else if (view_i.above_up) begin
            motion_d = MotWaitUp;
          end else if (below_car | keep) begin
            motion_d = MotWaitDown;
          end else begin
            motion_d = MotStop;
          end
        end
      end else if (motion_mid == MotDown) begin
        if (car_q == '0) begin
          motion_d = MotStop;
        end else begin
          car_d = car_q - SlotW'(1);
          if (!view_i.at_dn) begin
            motion_d = MotDown;
          end else if (below_dn) begin
            motion_d = MotWaitDown;
          end else if (above_car | keep) begin
            motion_d = MotWaitUp;
          end else begin
            motion_d = MotStop;
          end
        end
      end else begin
        motion_d = motion_mid;
      end
    end
    if (car_load_i) begin
      car_d = car_load_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q    <= '0;
      motion_q <= MotStop;
    end else begin
      car_q    <= car_d;
      motion_q <= motion_d;
    end
  end

  assign car_o      = car_q;
  assign car_p1_o   = car_p1;
  assign car_d_o    = car_d;
  assign motion_d_o = motion_d;
  assign served_o   = served;

`ifndef SYNTH
  a_step_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i && motion_q == MotUp && !top_hit && !car_load_i
    |=> car_q == $past(car_p1[SlotW-1:0]))
    else $error("Car moving up did not advance by one slot.");

  a_floor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i && motion_q == MotDown && car_q == '0 && !car_load_i
    |=> motion_q == MotStop && car_q == '0)
    else $error("Car moving down at the lowest slot did not stop in place.");

  a_serve_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    served_o |-> tick_i && view_i.at_car && motion_q != MotUp && motion_q != MotDown)
    else $error("Request served without a tick at a held car slot.");
`endif

endmodule

@@ design/elevator_scan_scheduler_top.sv @@
// SCAN elevator scheduler: one transaction per clock unless the output stalls, with results
// registered on acceptance; the scan runs in a row of per-slot request cells. The clock is set by the
// ripple of request flags through the cell chain and the esc_ctrl motion decision. Depends on esc_pkg.
module elevator_scan_scheduler_top #(
  parameter int unsigned StopSlots = esc_pkg::DefStopSlots
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [esc_pkg::ApbAddrW-1:0]        paddr,
  input  logic [esc_pkg::ApbDataW-1:0]        pwdata,
  output logic [esc_pkg::ApbDataW-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [esc_pkg::SlotW-1:0]           stop_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [esc_pkg::SlotW-1:0]           car_index_o,
  output logic signed [esc_pkg::FloorW-1:0]   floor_number_o,
  output logic [2:0]                          motion_o,
  output logic                                served_o,
  output logic                                rejected_o,
  output logic [esc_pkg::MapBits-1:0]         pending_o
);
  // Each transaction's result is registered on acceptance for the next cycle; transactions
  // may follow back to back. The path that sets the clock is the ripple of request flags
  // along the StopSlots cells and the motion decision that follows it.
  import esc_pkg::*;

  logic [1:0]             base_q;
  logic [4:0]             top_q;
  logic                   cfg_wr, car_load;
  logic [SlotW-1:0]       car_load_slot;
  logic                   in_acc, tick, slot_ok, in_range;
  cell_cmd_t              cmd;
  cell_view_t             views [StopSlots];
  cell_view_t             view_or;
  logic [StopSlots:0]     lo_chain;
  logic [StopSlots:1]     hi_chain;
  logic [StopSlots-1:0]   bits_d;
  logic [MapBits-1:0]     pending_d;
  logic [SlotW-1:0]       car_q, car_d;
  logic [SlotW:0]         car_p1;
  motion_e                motion_d;
  logic                   served;

  logic                   out_valid_q;
  logic [SlotW-1:0]       out_car_q;
  logic [FloorW-1:0]      out_floor_q;
  logic [2:0]             out_motion_q;
  logic                   out_served_q, out_rejected_q;
  logic [MapBits-1:0]     out_pending_q;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 2'd0;
      top_q  <= TopFloorReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegBasement: base_q <= pwdata[1:0];
        RegTopFloor: top_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegBasement: prdata = {{(ApbDataW - 2){1'b0}}, base_q};
      RegTopFloor: prdata = {{(ApbDataW - 5){1'b0}}, top_q};
      default:     prdata = '0;
    endcase
  end

  assign car_load      = cfg_wr && (paddr[2] == RegBasement);
  assign car_load_slot = (pwdata[1:0] != 2'd0) ? SlotW'(BaseSlots) : '0;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign tick       = in_acc && !mode_i;

  always_comb begin
    if (base_q == 2'd0) begin
      in_range = (top_q != 5'd0) && (stop_index_i < {1'b0, top_q});
    end else begin
      in_range = (stop_index_i >= SlotW'(BaseSlots) - SlotW'(base_q)) &&
                 (stop_index_i <= {1'b0, top_q} + SlotW'(2));
    end
  end
  assign slot_ok = in_range && ({1'b0, stop_index_i} < (SlotW + 1)'(StopSlots));

  assign cmd.car      = car_q;
  assign cmd.car_p1   = car_p1;
  assign cmd.set_en   = in_acc && mode_i && slot_ok;
  assign cmd.set_slot = stop_index_i;
  assign cmd.clr_en   = served;

  assign lo_chain[0]         = 1'b0;
  assign hi_chain[StopSlots] = 1'b0;

  for (genvar g = 0; g < StopSlots; g++) begin : g_cell
    if (g == 0) begin : g_low
      esc_cell #(.Idx(g)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .cmd_i   (cmd),
        .lo_i    (lo_chain[g]),
        .hi_i    (hi_chain[g+1]),
        .lo_o    (lo_chain[g+1]),
        .hi_o    (),
        .bit_d_o (bits_d[g]),
        .view_o  (views[g])
      );
    end else begin : g_mid
      esc_cell #(.Idx(g)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .cmd_i   (cmd),
        .lo_i    (lo_chain[g]),
        .hi_i    (hi_chain[g+1]),
        .lo_o    (lo_chain[g+1]),
        .hi_o    (hi_chain[g]),
        .bit_d_o (bits_d[g]),
        .view_o  (views[g])
      );
    end
  end

  always_comb begin
    view_or = '0;
    for (int i = 0; i < StopSlots; i++) begin
      view_or = cell_view_t'(view_or | views[i]);
    end
  end

  for (genvar k = 0; k < MapBits; k++) begin : g_map
    if (k < StopSlots) begin : g_bit
      assign pending_d[k] = bits_d[k];
    end else begin : g_pad
      assign pending_d[k] = 1'b0;
    end
  end

  esc_ctrl #(.StopSlots(StopSlots)) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_i          (tick),
    .view_i          (view_or),
    .all_or_i        (lo_chain[StopSlots]),
    .car_load_i      (car_load),
    .car_load_slot_i (car_load_slot),
    .car_o           (car_q),
    .car_p1_o        (car_p1),
    .car_d_o         (car_d),
    .motion_d_o      (motion_d),
    .served_o        (served)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_car_q      <= car_d;
      out_floor_q    <= floor_of(car_d, base_q);
      out_motion_q   <= motion_d;
      out_served_q   <= served;
      out_rejected_q <= mode_i && !slot_ok;
      out_pending_q  <= pending_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign car_index_o    = out_car_q;
  assign floor_number_o = signed'(out_floor_q);
  assign motion_o       = out_motion_q;
  assign served_o       = out_served_q;
  assign rejected_o     = out_rejected_q;
  assign pending_o      = out_pending_q;

endmodule

@@ bench/tb_elevator_scan_scheduler_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for elevator_scan_scheduler_top: a directed table, then random
// phases under several building settings. Each result is checked against the table's expected
// report or an in-bench SCAN predictor. Depends on esc_pkg and the design files.
module tb_elevator_scan_scheduler_top;
  import esc_pkg::*;

  localparam int StopSlots = DefStopSlots;
  localparam int NumDirRows = 22;
  localparam int NumPhases = 16;
  localparam int PhaseItems = 114;

  typedef struct packed {
    logic [SlotW-1:0]   car;
    logic [FloorW-1:0]  floor_no;
    logic [2:0]         motion;
    logic               served;
    logic               rejected;
    logic [MapBits-1:0] pending;
  } car_report_t;

  typedef struct packed {
    logic             m;
    logic [SlotW-1:0] idx;
    logic             typed;
    car_report_t      want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic [SlotW-1:0] stop_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SlotW-1:0] car_index_o;
  logic signed [FloorW-1:0] floor_number_o;
  logic [2:0] motion_o;
  logic served_o;
  logic rejected_o;
  logic [MapBits-1:0] pending_o;

  elevator_scan_scheduler_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .stop_index_i   (stop_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .car_index_o    (car_index_o),
    .floor_number_o (floor_number_o),
    .motion_o       (motion_o),
    .served_o       (served_o),
    .rejected_o     (rejected_o),
    .pending_o      (pending_o)
  );

  logic [MapBits-1:0] req_map = '0;
  logic [SlotW-1:0]   car_slot = '0;
  motion_e            car_mot = MotStop;
  logic [1:0]         cfg_base = 2'd0;
  logic [4:0]         cfg_top = TopFloorReset;

  car_report_t due_reports[$];
  stim_row_t   dir_rows[NumDirRows];
  int          mismatches = 0;
  int          orphan_reports = 0;
  int          reports_seen = 0;
  bit          tx_burst = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_elevator_scan_scheduler_top: errors");
    $finish;
  end

  function automatic bit building_span(output int lo, output int hi);
    if (cfg_base == 2'd0) begin
      lo = 0;
      hi = int'(cfg_top) - 1;
      return cfg_top != 5'd0;
    end
    lo = int'(BaseSlots) - int'(cfg_base);
    hi = int'(cfg_top) + 2;
    return 1'b1;
  endfunction

  function automatic bit slot_in_building(input int s);
    int lo, hi;
    if (s >= StopSlots || !building_span(lo, hi)) return 1'b0;
    return s >= lo && s <= hi;
  endfunction

  function automatic bit pending_above(input logic [SlotW-1:0] s);
    return ((req_map >> s) >> 1) != '0;
  endfunction

  function automatic bit pending_below(input logic [SlotW-1:0] s);
    return (req_map & ((MapBits'(1) << s) - MapBits'(1))) != '0;
  endfunction

  // Request: store or reject. SCAN step: service at the car slot, then one slot of travel and the arrival decision.
  function automatic car_report_t advance_car(input logic m, input logic [SlotW-1:0] idx);
    car_report_t r;
    r = '0;
    if (m) begin
      if (slot_in_building(int'(idx))) req_map[idx] = 1'b1;
      else r.rejected = 1'b1;
    end else begin
      if (car_mot == MotStop || car_mot == MotWaitUp || car_mot == MotWaitDown) begin
        if (req_map[car_slot]) begin
          req_map[car_slot] = 1'b0;
          r.served = 1'b1;
          if (car_mot == MotWaitUp) car_mot = MotUp;
          else if (car_mot == MotWaitDown) car_mot = MotDown;
        end else if (pending_below(car_slot)) begin
          car_mot = MotDown;
        end else if (pending_above(car_slot)) begin
          car_mot = MotUp;
        end
      end
      if (car_mot == MotUp) begin
        if (int'(car_slot) + 1 >= StopSlots) begin
          car_mot = MotStop;
        end else begin
          car_slot = car_slot + 1'b1;
          if (req_map[car_slot]) begin
            if (pending_above(car_slot)) car_mot = MotWaitUp;
            else if (pending_below(car_slot)) car_mot = MotWaitDown;
            else car_mot = MotStop;
          end
        end
      end else if (car_mot == MotDown) begin
        if (car_slot == '0) begin
          car_mot = MotStop;
        end else begin
          car_slot = car_slot - 1'b1;
          if (req_map[car_slot]) begin
            if (pending_below(car_slot)) car_mot = MotWaitDown;
            else if (pending_above(car_slot)) car_mot = MotWaitUp;
            else car_mot = MotStop;
          end
        end
      end
    end
    r.car = car_slot;
    if (cfg_base == 2'd0) r.floor_no = car_slot + FloorW'(1);
    else if (car_slot >= SlotW'(BaseSlots)) r.floor_no = car_slot - FloorW'(2);
    else r.floor_no = car_slot - FloorW'(3);
    r.motion = car_mot;
    r.pending = req_map;
    return r;
  endfunction

  task automatic drive_item(input logic m, input logic [SlotW-1:0] idx, input logic typed,
                            input car_report_t want);
    int gap;
    car_report_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    stop_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    pred = advance_car(m, idx);
    due_reports.push_back(typed ? want : pred);
  endtask

  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] value);
    logic [ApbDataW-1:0] data;
    data = ($urandom & ~32'h1f) | ApbDataW'(value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegBasement) begin
      cfg_base = data[1:0];
      car_slot = (cfg_base != 2'd0) ? SlotW'(BaseSlots) : '0;
    end else begin
      cfg_top = data[4:0];
    end
  endtask

  task automatic note_mismatch(input string field, input logic [MapBits-1:0] want,
                               input logic [MapBits-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at %0t: expected %0h, got %0h", field, $realtime, want, got);
  endtask

  task automatic check_report();
    car_report_t want;
    if (due_reports.size() == 0) begin
      orphan_reports++;
      $display("result with no pending transaction at %0t", $realtime);
    end else begin
      want = due_reports.pop_front();
      if (car_index_o !== want.car)
        note_mismatch("car_index", MapBits'(want.car), MapBits'(car_index_o));
      if (floor_number_o !== want.floor_no)
        note_mismatch("floor_number", MapBits'(want.floor_no),
                      MapBits'($unsigned(floor_number_o)));
      if (motion_o !== want.motion)
        note_mismatch("motion", MapBits'(want.motion), MapBits'(motion_o));
      if (served_o !== want.served)
        note_mismatch("served", MapBits'(want.served), MapBits'(served_o));
      if (rejected_o !== want.rejected)
        note_mismatch("rejected", MapBits'(want.rejected), MapBits'(rejected_o));
      if (pending_o !== want.pending) note_mismatch("pending", want.pending, pending_o);
    end
  endtask

  // The output side stalls at random, never in some windows, and once for a long stretch so the block backs up.
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (reports_seen == 500) gap = 300;
      else if ((reports_seen / 150) % 3 == 2) gap = 0;
      else gap = $urandom_range(0, 3);
      repeat (gap) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_report();
      reports_seen++;
    end
  end

  initial begin
    int lo, hi, base_sel, top_sel;
    bit has_span;
    logic m;
    logic [SlotW-1:0] idx;
    int fixed_base[6];
    int fixed_top[6];
    fixed_base = '{3, 0, 1, 0, 2, 0};
    fixed_top = '{30, 0, 31, 31, 1, 1};
    dir_rows = '{
      '{1'b0, 6'd0,  1'b1, '{6'd0, 6'd1, MotStop, 1'b0, 1'b0, 33'h0}},
      '{1'b1, 6'd63, 1'b1, '{6'd0, 6'd1, MotStop, 1'b0, 1'b1, 33'h0}},
      '{1'b1, 6'd32, 1'b1, '{6'd0, 6'd1, MotStop, 1'b0, 1'b1, 33'h0}},
      '{1'b1, 6'd30, 1'b1, '{6'd0, 6'd1, MotStop, 1'b0, 1'b1, 33'h0}},
      '{1'b1, 6'd29, 1'b1, '{6'd0, 6'd1, MotStop, 1'b0, 1'b0, 33'h0_2000_0000}},
      '{1'b1, 6'd0,  1'b1, '{6'd0, 6'd1, MotStop, 1'b0, 1'b0, 33'h0_2000_0001}},
      '{1'b0, 6'd0,  1'b1, '{6'd0, 6'd1, MotStop, 1'b1, 1'b0, 33'h0_2000_0000}},
      '{1'b1, 6'd1,  1'b0, '0},
      '{1'b0, 6'd0,  1'b0, '0},
      '{1'b0, 6'd63, 1'b0, '0},
      '{1'b1, 6'd5,  1'b0, '0},
      '{1'b0, 6'd0,  1'b0, '0},
      '{1'b1, 6'd2,  1'b0, '0},
      '{1'b0, 6'd0,  1'b0, '0},
      '{1'b0, 6'd0,  1'b0, '0},
      '{1'b1, 6'd42, 1'b0, '0},
      '{1'b0, 6'd0,  1'b0, '0},
      '{1'b1, 6'd21, 1'b0, '0},
      '{1'b0, 6'd21, 1'b0, '0},
      '{1'b0, 6'd0,  1'b0, '0},
      '{1'b0, 6'd0,  1'b0, '0},
      '{1'b0, 6'd0,  1'b0, '0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      drive_item(dir_rows[i].m, dir_rows[i].idx, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_reports();
      if (ph < 6) begin
        base_sel = fixed_base[ph];
        top_sel = fixed_top[ph];
      end else begin
        base_sel = $urandom_range(0, 3);
        top_sel = $urandom_range(0, 31);
      end
      if ($urandom_range(0, 1)) begin
        write_reg(RegBasement, 5'(base_sel));
        write_reg(RegTopFloor, 5'(top_sel));
      end else begin
        write_reg(RegTopFloor, 5'(top_sel));
        write_reg(RegBasement, 5'(base_sel));
      end
      tx_burst = (ph % 4 == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        has_span = building_span(lo, hi);
        m = ($urandom_range(0, 99) >= 58);
        if (has_span && $urandom_range(0, 4) != 0)
          idx = SlotW'($urandom_range(lo, (hi < StopSlots) ? hi : StopSlots - 1));
        else
          idx = SlotW'($urandom_range(0, 63));
        drive_item(m, idx, 1'b0, '0);
      end
    end

    drain_reports();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && orphan_reports == 0 && due_reports.size() == 0) begin
      $display("tb_elevator_scan_scheduler_top: clean");
    end else begin
      $display("tb_elevator_scan_scheduler_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/esc_pkg.sv
design/esc_cell.sv
design/esc_ctrl.sv
design/elevator_scan_scheduler_top.sv
bench/tb_elevator_scan_scheduler_top.sv
